// ===== hw/rtl/pncm_pkg.sv =====
// ----------------------------------------------------------------------------
// pncm_pkg
// shared constants, types and codes of the penalised nearest colour match
// ----------------------------------------------------------------------------
package pncm_pkg;

  // table size and derived widths
  localparam int unsigned MAX_ENTRIES = 1024;
  localparam int unsigned IDX_W       = $clog2(MAX_ENTRIES);
  localparam int unsigned CNT_W       = $clog2(MAX_ENTRIES + 1);

  // field widths
  localparam int unsigned CFG_W       = 11;
  localparam int unsigned IN_INDEX_W  = 10;
  localparam int unsigned CHAN_W      = 8;
  localparam int unsigned COLOR_W     = 3 * CHAN_W;
  localparam int unsigned USES_W      = 16;
  localparam int unsigned OUT_INDEX_W = 10;
  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_TDATA_W = 32;

  // scoring widths
  localparam int unsigned D2_W    = 18;
  localparam int unsigned WGT_W   = USES_W + 1;
  localparam int unsigned P_W     = D2_W + WGT_W;
  localparam int unsigned SCORE_W = 27;
  localparam int unsigned S_W     = SCORE_W + WGT_W;

  localparam logic [CFG_W-1:0]   CFG_RESET = CFG_W'(1024);
  localparam logic [SCORE_W-1:0] LIMIT_SQ  = SCORE_W'(100000000);
  localparam logic [USES_W-1:0]  USES_MAX  = '1;

  // function codes carried on tuser
  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_FETCH,
    ST_UPDATE
  } pncm_state_e;

  typedef struct packed {
    logic load;
    logic start;
    logic scan;
    logic clr;
    logic update;
  } pncm_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic scan_done;
    logic out_free;
  } pncm_sts_t;

endpackage

// ===== hw/rtl/pncm_ram.sv =====
// ----------------------------------------------------------------------------
// pncm_ram
// simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module pncm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/pncm_ctrl.sv =====
// ----------------------------------------------------------------------------
// pncm_ctrl
// sequencer: clearing pass, loads, query scan, count update
// ----------------------------------------------------------------------------
module pncm_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_func_i,
  output logic               in_ready_o,
  input  pncm_pkg::pncm_sts_t sts_i,
  output pncm_pkg::pncm_cmd_t cmd_o
);

  pncm_pkg::pncm_state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pncm_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      pncm_pkg::ST_CLEAR: begin
        cmd_o.clr = 1'b1;
        if (sts_i.clr_last) begin
          state_d = pncm_pkg::ST_IDLE;
        end
      end
      pncm_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_func_i == pncm_pkg::FUNC_LOAD) begin
            cmd_o.load = 1'b1;
          end else begin
            cmd_o.start = 1'b1;
            state_d     = pncm_pkg::ST_SCAN;
          end
        end
      end
      pncm_pkg::ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_done) begin
          state_d = pncm_pkg::ST_FETCH;
        end
      end
      pncm_pkg::ST_FETCH: begin
        // count of the winner is read this cycle
        state_d = pncm_pkg::ST_UPDATE;
      end
      pncm_pkg::ST_UPDATE: begin
        if (sts_i.out_free) begin
          cmd_o.update = 1'b1;
          state_d      = pncm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = pncm_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== hw/rtl/pncm_dp.sv =====
// ----------------------------------------------------------------------------
// pncm_dp
// datapath: colour and count tables, scoring pipeline, best tracker, output
// ----------------------------------------------------------------------------
module pncm_dp (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  pncm_pkg::pncm_cmd_t                cmd_i,
  output pncm_pkg::pncm_sts_t                sts_o,
  input  logic                               cfg_we_i,
  input  logic [pncm_pkg::CFG_W-1:0]         cfg_wdata_i,
  input  logic [pncm_pkg::IN_INDEX_W-1:0]    in_index_i,
  input  logic [pncm_pkg::CHAN_W-1:0]        in_red_i,
  input  logic [pncm_pkg::CHAN_W-1:0]        in_green_i,
  input  logic [pncm_pkg::CHAN_W-1:0]        in_blue_i,
  input  logic                               out_ready_i,
  output logic                               out_valid_o,
  output logic [pncm_pkg::OUT_INDEX_W-1:0]   out_index_o,
  output logic [pncm_pkg::USES_W-1:0]        out_uses_o,
  output logic                               out_within_o
);

  localparam int unsigned IDX_W = pncm_pkg::IDX_W;
  localparam int unsigned CNT_W = pncm_pkg::CNT_W;
  localparam int unsigned CH_W  = pncm_pkg::CHAN_W;

  // configuration and scan control
  logic [pncm_pkg::CFG_W-1:0] cfg_q;
  logic [CNT_W-1:0]           count_q, count_d;
  logic [CNT_W-1:0]           addr_q, addr_d;
  logic                       issue;

  // query colour
  logic [CH_W-1:0] qr_q, qg_q, qb_q;

  // ram ports
  logic                           col_we;
  logic [pncm_pkg::COLOR_W-1:0]   col_rdata;
  logic                           use_we;
  logic [IDX_W-1:0]               use_waddr, use_raddr;
  logic [pncm_pkg::USES_W-1:0]    use_wdata, use_rdata, use_inc;
  logic                           load_ok;

  // pipeline stages
  logic                          v0_q, v1_q, v2_q, v3_q;
  logic [IDX_W-1:0]              tag0_q, tag1_q, tag2_q, tag3_q;
  logic [pncm_pkg::D2_W-1:0]     d2_d, d2_q;
  logic [pncm_pkg::WGT_W-1:0]    w1_q, w2_q;
  logic [pncm_pkg::P_W-1:0]      p_full;
  logic [pncm_pkg::SCORE_W-1:0]  p_sat, p_q;
  logic [pncm_pkg::S_W-1:0]      s_q;
  logic [CH_W-1:0]               dr, dg, db;

  // best tracker
  logic [pncm_pkg::SCORE_W-1:0]  best_score_q;
  logic [IDX_W-1:0]              best_q;
  logic                          found_q;
  logic                          better;

  // output register
  logic                             out_valid_q;
  logic [pncm_pkg::OUT_INDEX_W-1:0] out_index_q;
  logic [pncm_pkg::USES_W-1:0]      out_uses_q;
  logic                             out_within_q;

  // tables
  pncm_ram #(
    .WIDTH (pncm_pkg::COLOR_W),
    .DEPTH (pncm_pkg::MAX_ENTRIES)
  ) u_col_ram (
    .clk_i   (clk_i),
    .we_i    (col_we),
    .waddr_i (IDX_W'(in_index_i)),
    .wdata_i ({in_red_i, in_green_i, in_blue_i}),
    .raddr_i (addr_q[IDX_W-1:0]),
    .rdata_o (col_rdata)
  );

  pncm_ram #(
    .WIDTH (pncm_pkg::USES_W),
    .DEPTH (pncm_pkg::MAX_ENTRIES)
  ) u_use_ram (
    .clk_i   (clk_i),
    .we_i    (use_we),
    .waddr_i (use_waddr),
    .wdata_i (use_wdata),
    .raddr_i (use_raddr),
    .rdata_o (use_rdata)
  );

  // table write and read selection
  assign load_ok   = cmd_i.load && (32'(in_index_i) < pncm_pkg::MAX_ENTRIES);
  assign col_we    = load_ok;
  assign use_inc   = (use_rdata == pncm_pkg::USES_MAX) ? use_rdata : use_rdata + 1'b1;
  assign use_raddr = cmd_i.scan ? addr_q[IDX_W-1:0] : best_q;

  always_comb begin
    use_we    = cmd_i.clr || load_ok || cmd_i.update;
    use_waddr = best_q;
    use_wdata = '0;
    if (cmd_i.clr) begin
      use_waddr = addr_q[IDX_W-1:0];
    end else if (cmd_i.load) begin
      use_waddr = IDX_W'(in_index_i);
    end else if (cmd_i.update) begin
      use_wdata = use_inc;
    end
  end

  // scan counter, also walks the clearing pass
  assign issue = cmd_i.scan && (addr_q < count_q);

  always_comb begin
    addr_d  = addr_q;
    count_d = count_q;
    if (cmd_i.start) begin
      addr_d = '0;
      if (32'(cfg_q) > pncm_pkg::MAX_ENTRIES) begin
        count_d = CNT_W'(pncm_pkg::MAX_ENTRIES);
      end else begin
        count_d = CNT_W'(cfg_q);
      end
    end else if (cmd_i.clr || issue) begin
      addr_d = addr_q + 1'b1;
    end
  end

  // stage one: squared colour distance
  always_comb begin
    dr = (qr_q > col_rdata[23:16]) ? qr_q - col_rdata[23:16] : col_rdata[23:16] - qr_q;
    dg = (qg_q > col_rdata[15:8])  ? qg_q - col_rdata[15:8]  : col_rdata[15:8]  - qg_q;
    db = (qb_q > col_rdata[7:0])   ? qb_q - col_rdata[7:0]   : col_rdata[7:0]   - qb_q;
    d2_d = pncm_pkg::D2_W'(dr) * pncm_pkg::D2_W'(dr)
         + pncm_pkg::D2_W'(dg) * pncm_pkg::D2_W'(dg)
         + pncm_pkg::D2_W'(db) * pncm_pkg::D2_W'(db);
  end

  // stage two: first weighting, clamped since anything past the limit stays past it
  assign p_full = pncm_pkg::P_W'(d2_q) * pncm_pkg::P_W'(w1_q);
  assign p_sat  = (p_full[pncm_pkg::P_W-1:pncm_pkg::SCORE_W] != '0) ? '1
                : p_full[pncm_pkg::SCORE_W-1:0];

  // stage four: strict compare keeps the first of equal scores
  assign better = v3_q && (s_q < pncm_pkg::S_W'(best_score_q));

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q       <= pncm_pkg::CFG_RESET;
      addr_q      <= '0;
      v0_q        <= 1'b0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
      addr_q <= addr_d;
      v0_q   <= issue;
      v1_q   <= v0_q;
      v2_q   <= v1_q;
      v3_q   <= v2_q;
      if (cmd_i.update) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    count_q <= count_d;
    if (cmd_i.start) begin
      qr_q         <= in_red_i;
      qg_q         <= in_green_i;
      qb_q         <= in_blue_i;
      best_score_q <= pncm_pkg::LIMIT_SQ;
      best_q       <= '0;
      found_q      <= 1'b0;
    end else if (better) begin
      best_score_q <= s_q[pncm_pkg::SCORE_W-1:0];
      best_q       <= tag3_q;
      found_q      <= 1'b1;
    end
    tag0_q <= addr_q[IDX_W-1:0];
    tag1_q <= tag0_q;
    tag2_q <= tag1_q;
    tag3_q <= tag2_q;
    d2_q   <= d2_d;
    w1_q   <= pncm_pkg::WGT_W'(use_rdata) + 1'b1;
    p_q    <= p_sat;
    w2_q   <= w1_q;
    s_q    <= pncm_pkg::S_W'(p_q) * pncm_pkg::S_W'(w2_q);
    if (cmd_i.update) begin
      out_index_q  <= pncm_pkg::OUT_INDEX_W'(best_q);
      out_uses_q   <= use_inc;
      out_within_q <= found_q;
    end
  end

  // status to the sequencer
  assign sts_o.clr_last  = (addr_q == CNT_W'(pncm_pkg::MAX_ENTRIES - 1));
  assign sts_o.scan_done = (addr_q >= count_q) && !v0_q && !v1_q && !v2_q && !v3_q;
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o  = out_valid_q;
  assign out_index_o  = out_index_q;
  assign out_uses_o   = out_uses_q;
  assign out_within_o = out_within_q;

endmodule

// ===== hw/rtl/penalized_nearest_color_match.sv =====
// ----------------------------------------------------------------------------
// penalized_nearest_color_match
// usage-penalised nearest colour search over a table of tile colours
// ----------------------------------------------------------------------------
// Input stream: tuser picks the function. A load beat writes one tile colour
// and clears its usage count; it gives no output beat.
// A query beat carries a block colour; the block scans entries
// 0 .. entries_in_use-1 and sends one output beat with the chosen index,
// its incremented count and the within-limit flag.
// Values of entries_in_use above 1024 scan 1024 entries; the colour and
// count rams are read one entry per cycle during the scan.
// One item is worked on at a time; tready is high only when idle.
// The result waits in an output register, so loads and a new query are
// taken while it is stalled; a query only finishes once that register frees.
// After reset a clearing pass zeroes all 1024 usage counts, and
// no input beat is taken during it; configuration writes are always taken.
// cfg_we_i writes entries_in_use (reset 1024) and must only be used while
// the block is idle.
// ----------------------------------------------------------------------------
module penalized_nearest_color_match (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [pncm_pkg::CFG_W-1:0]          cfg_wdata_i,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // entry_index [9:0], red [17:10], green [25:18], blue [33:26], zero [39:34]
  input  logic [pncm_pkg::IN_TDATA_W-1:0]     s_axis_tdata_i,
  // func [0]
  input  logic                                s_axis_tuser_i,
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  // match_index [9:0], match_uses [25:10], zero [31:26]
  output logic [pncm_pkg::OUT_TDATA_W-1:0]    m_axis_tdata_o,
  // within_limit [0]
  output logic                                m_axis_tuser_o
);

  pncm_pkg::pncm_cmd_t cmd;
  pncm_pkg::pncm_sts_t sts;

  logic [pncm_pkg::OUT_INDEX_W-1:0] out_index;
  logic [pncm_pkg::USES_W-1:0]      out_uses;

  // sequencer
  pncm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_func_i  (s_axis_tuser_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // datapath
  pncm_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_index_i   (s_axis_tdata_i[9:0]),
    .in_red_i     (s_axis_tdata_i[17:10]),
    .in_green_i   (s_axis_tdata_i[25:18]),
    .in_blue_i    (s_axis_tdata_i[33:26]),
    .out_ready_i  (m_axis_tready_i),
    .out_valid_o  (m_axis_tvalid_o),
    .out_index_o  (out_index),
    .out_uses_o   (out_uses),
    .out_within_o (m_axis_tuser_o)
  );

  // output packing
  assign m_axis_tdata_o = {6'b0, out_uses, out_index};

endmodule

// ===== hw/rtl/pncm_chk.sv =====
// ----------------------------------------------------------------------------
// pncm_chk
// port-level checks on the result stream
// ----------------------------------------------------------------------------
module pncm_chk (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             m_axis_tvalid_o,
  input logic                             m_axis_tready_i,
  input logic [pncm_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o,
  input logic                             m_axis_tuser_o
);

  // a stalled result beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("stalled result beat changed");

  // fallback always reports entry zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o |-> m_axis_tdata_o[9:0] == 10'd0)
    else $error("fallback beat with non-zero index");

  // the chosen entry has just been counted, so its count is never zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[25:10] != 16'd0)
    else $error("result count is zero");

  // padding bits stay clear
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[31:26] == 6'd0)
    else $error("tdata padding not zero");

endmodule

bind penalized_nearest_color_match pncm_chk u_pncm_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);

// ===== test/tb_penalized_nearest_color_match.sv =====
// ----------------------------------------------------------------------------
// tb_penalized_nearest_color_match
// self-checking bench for the penalised nearest colour match
// ----------------------------------------------------------------------------
// Fills the low part of the tile table first and keeps every scan length
// inside it, so no query ever reads an unwritten entry. Directed queries
// then cover exact hits at the colour extremes, ties, and a zero scan length
// that keeps falling back to entry 0 until its count is high enough that a
// distant colour misses the score limit. Random load and query traffic
// follows over several scan lengths. A scoreboard keeps its own table and
// counts, predicts each query result when the beat is taken, and checks
// output beats in order. Both stream sides idle at random. The receiver is
// held off once so that the block backs up.
// ----------------------------------------------------------------------------
module tb_penalized_nearest_color_match;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_ENTRIES = pncm_pkg::MAX_ENTRIES;
  localparam int unsigned IN_INDEX_W  = pncm_pkg::IN_INDEX_W;
  localparam int unsigned CHAN_W      = pncm_pkg::CHAN_W;
  localparam int unsigned CFG_W       = pncm_pkg::CFG_W;
  localparam int unsigned USES_W      = pncm_pkg::USES_W;
  localparam int unsigned OUT_INDEX_W = pncm_pkg::OUT_INDEX_W;
  localparam int unsigned IN_TDATA_W  = pncm_pkg::IN_TDATA_W;
  localparam int unsigned OUT_TDATA_W = pncm_pkg::OUT_TDATA_W;

  localparam logic [CFG_W-1:0]  CFG_RESET = pncm_pkg::CFG_RESET;
  localparam longint unsigned   LIMIT_SQ  = pncm_pkg::LIMIT_SQ;
  localparam logic [USES_W-1:0] USES_MAX  = pncm_pkg::USES_MAX;

  localparam int unsigned HOLD_CYCLES      = 3000;
  localparam int unsigned STALL_LIMIT      = 20000;
  localparam int unsigned SETTLE_CYCLES    = 16;
  localparam int unsigned TAIL_CYCLES      = 1100;
  localparam int unsigned FILL_ENTRIES     = 128;
  localparam int unsigned FALLBACK_QUERIES = 30;
  localparam int unsigned MAX_REPORTS      = 10;
  localparam int unsigned RED_LSB          = IN_INDEX_W;
  localparam int unsigned GREEN_LSB        = RED_LSB + CHAN_W;
  localparam int unsigned BLUE_LSB         = GREEN_LSB + CHAN_W;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } rgb_t;

  typedef struct packed {
    logic [OUT_INDEX_W-1:0] index;
    logic [USES_W-1:0]      uses;
    logic                   in_limit;
  } match_t;

  // tile table copy, usage counts and the matches still owed by the block
  class colour_match_board;
    rgb_t              tile_rgb  [MAX_ENTRIES];
    logic [USES_W-1:0] tile_uses [MAX_ENTRIES];
    logic [CFG_W-1:0]  scan_len;
    match_t            due_matches [$];
    int unsigned       mismatches;

    function new();
      foreach (tile_uses[i]) begin
        tile_uses[i] = '0;
        tile_rgb[i]  = '0;
      end
      scan_len   = CFG_RESET;
      mismatches = 0;
    endfunction

    function void set_scan_len(logic [CFG_W-1:0] len);
      scan_len = len;
    endfunction

    function bit all_matched();
      return due_matches.size() == 0;
    endfunction

    function longint unsigned chan_sq(logic [CHAN_W-1:0] a, logic [CHAN_W-1:0] b);
      longint unsigned d;
      d = (a > b) ? (a - b) : (b - a);
      return d * d;
    endfunction

    // a load rewrites one entry, a query owes one match
    function void take_item(logic func, logic [IN_TDATA_W-1:0] data);
      logic [IN_INDEX_W-1:0] idx;
      rgb_t                  want;
      int unsigned           span;
      int unsigned           i;
      int unsigned           best;
      longint unsigned       d2;
      longint unsigned       wgt;
      longint unsigned       score;
      longint unsigned       best_score;
      bit                    found;
      match_t                m;
      idx        = data[IN_INDEX_W-1:0];
      want.red   = data[RED_LSB +: CHAN_W];
      want.green = data[GREEN_LSB +: CHAN_W];
      want.blue  = data[BLUE_LSB +: CHAN_W];
      if (func == pncm_pkg::FUNC_LOAD) begin
        tile_rgb[idx]  = want;
        tile_uses[idx] = '0;
        return;
      end
      span       = (scan_len > MAX_ENTRIES) ? MAX_ENTRIES : scan_len;
      best_score = LIMIT_SQ;
      best       = 0;
      found      = 1'b0;
      // squared distance times squared weight, strict compare keeps the lowest index
      for (i = 0; i < span; i++) begin
        d2 = chan_sq(want.red, tile_rgb[i].red) + chan_sq(want.green, tile_rgb[i].green)
           + chan_sq(want.blue, tile_rgb[i].blue);
        wgt   = tile_uses[i];
        wgt   = wgt + 1;
        score = d2 * wgt * wgt;
        if (score < best_score) begin
          best_score = score;
          best       = i;
          found      = 1'b1;
        end
      end
      if (tile_uses[best] != USES_MAX) tile_uses[best] = tile_uses[best] + 1'b1;
      m.index    = best[OUT_INDEX_W-1:0];
      m.uses     = tile_uses[best];
      m.in_limit = found;
      due_matches = {due_matches, m};
    endfunction

    function void check_match(logic [OUT_TDATA_W-1:0] data, logic user);
      match_t got;
      match_t want;
      got.index    = data[OUT_INDEX_W-1:0];
      got.uses     = data[OUT_INDEX_W +: USES_W];
      got.in_limit = user;
      if (due_matches.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: unexpected result beat: index %0d uses %0d within %0b",
                   $realtime, got.index, got.uses, got.in_limit);
        return;
      end
      want = due_matches.pop_front();
      if (got.index !== want.index || got.uses !== want.uses
          || got.in_limit !== want.in_limit) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: result differs: index %0d/%0d uses %0d/%0d within %0b/%0b (exp/got)",
                   $realtime, want.index, got.index, want.uses, got.uses,
                   want.in_limit, got.in_limit);
      end
    endfunction
  endclass

  logic                   clk_i     = 1'b0;
  logic                   rst_n     = 1'b0;
  logic                   cfg_we    = 1'b0;
  logic [CFG_W-1:0]       cfg_wdata = '0;
  logic                   s_tvalid  = 1'b0;
  logic [IN_TDATA_W-1:0]  s_tdata   = '0;
  logic                   s_tuser   = 1'b0;
  logic                   m_tready  = 1'b0;
  logic                   s_axis_tready_o;
  logic                   m_axis_tvalid_o;
  logic [OUT_TDATA_W-1:0] m_axis_tdata_o;
  logic                   m_axis_tuser_o;

  int unsigned send_idle_pct = 36;
  int unsigned recv_idle_pct = 85;
  bit          recv_hold     = 1'b0;
  int unsigned quiet_cycles  = 0;

  colour_match_board board = new();

  penalized_nearest_color_match dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // receiver: random back-pressure, or one long hold when asked
  initial begin
    forever begin
      @(posedge clk_i);
      if (recv_hold) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        recv_hold = 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // beat monitor feeding the scoreboard
  always @(posedge clk_i) begin
    if (rst_n) begin
      if (m_axis_tvalid_o && m_tready) board.check_match(m_axis_tdata_o, m_axis_tuser_o);
      if (cfg_we) board.set_scan_len(cfg_wdata);
      if (s_tvalid && s_axis_tready_o) board.take_item(s_tuser, s_tdata);
    end
  end

  // watchdog on cycles without any beat or register write
  always @(posedge clk_i) begin
    if (!rst_n || cfg_we || (s_tvalid && s_axis_tready_o) || (m_axis_tvalid_o && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // random channels, half of them from a small palette so that ties occur
  function automatic rgb_t rand_rgb();
    rgb_t c;
    logic [CHAN_W-1:0] pick [3];
    foreach (pick[k]) begin
      if ($urandom_range(1)) begin
        pick[k] = CHAN_W'($urandom);
      end else begin
        case ($urandom_range(3))
          0: pick[k] = '0;
          1: pick[k] = '1;
          2: pick[k] = 8'h80;
          default: pick[k] = 8'h40;
        endcase
      end
    end
    c.red   = pick[0];
    c.green = pick[1];
    c.blue  = pick[2];
    return c;
  endfunction

  // offer one beat after a random gap, return at the edge that takes it
  task automatic send_beat(input logic func, input logic [IN_INDEX_W-1:0] idx, input rgb_t c);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= func;
    s_tdata  <= IN_TDATA_W'({c.blue, c.green, c.red, idx});
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
  endtask

  // stop offering and wait for every owed match, then let a load finish
  task automatic wait_all_matched();
    s_tvalid <= 1'b0;
    @(posedge clk_i);
    while (!board.all_matched()) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_scan_length(input int unsigned len);
    wait_all_matched();
    cfg_we    <= 1'b1;
    cfg_wdata <= CFG_W'(len);
    @(posedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  // random loads and queries; loads mostly land inside the scanned range
  task automatic random_traffic(input int unsigned len, input int unsigned n_items);
    int unsigned           span;
    int unsigned           k;
    logic [IN_INDEX_W-1:0] idx;
    write_scan_length(len);
    span = (len > MAX_ENTRIES) ? MAX_ENTRIES : ((len == 0) ? 1 : len);
    for (k = 0; k < n_items; k++) begin
      idx = ($urandom_range(3) == 0) ? IN_INDEX_W'($urandom)
                                     : IN_INDEX_W'($urandom_range(span - 1));
      if ($urandom_range(9) < 4)
        send_beat(pncm_pkg::FUNC_LOAD, idx, rand_rgb());
      else if ($urandom_range(2) == 0)
        send_beat(pncm_pkg::FUNC_QUERY, IN_INDEX_W'($urandom), board.tile_rgb[idx]);
      else
        send_beat(pncm_pkg::FUNC_QUERY, IN_INDEX_W'($urandom), rand_rgb());
    end
  endtask

  initial begin : stimulus
    rgb_t        c;
    int unsigned i;
    repeat (7) @(posedge clk_i);
    rst_n <= 1'b1;

    // fill the low entries, black at the bottom and white at the top
    for (i = 0; i < FILL_ENTRIES; i++) begin
      c = rand_rgb();
      if (i == 0) c = '0;
      if (i == FILL_ENTRIES - 1) c = '1;
      send_beat(pncm_pkg::FUNC_LOAD, IN_INDEX_W'(i), c);
    end

    // exact hits at both colour extremes over the filled range
    write_scan_length(FILL_ENTRIES);
    send_beat(pncm_pkg::FUNC_QUERY, '0, '0);
    send_beat(pncm_pkg::FUNC_QUERY, '1, '1);

    // three equal entries: the lowest index wins, also once its count grows
    write_scan_length(4);
    c = '{8'h40, 8'h80, 8'hc0};
    for (i = 1; i < 4; i++) send_beat(pncm_pkg::FUNC_LOAD, IN_INDEX_W'(i), c);
    send_beat(pncm_pkg::FUNC_QUERY, IN_INDEX_W'($urandom), c);
    send_beat(pncm_pkg::FUNC_QUERY, IN_INDEX_W'($urandom), c);

    // sender lightly idle, receiver mostly stalled
    random_traffic(3, 40);
    random_traffic(64, 40);
    random_traffic(1, 40);

    // the other way round
    send_idle_pct = 85;
    recv_idle_pct = 36;
    random_traffic(FILL_ENTRIES, 25);
    random_traffic(16, 40);
    random_traffic(2, 40);

    // no idling; first the receiver is held off while beats keep coming
    send_idle_pct = 0;
    recv_idle_pct = 0;
    recv_hold = 1'b1;
    for (i = 0; i < 10; i++)
      send_beat((i % 3 == 2) ? pncm_pkg::FUNC_LOAD : pncm_pkg::FUNC_QUERY,
                IN_INDEX_W'($urandom_range(3)), rand_rgb());
    wait_all_matched();

    // zero scan length: every query falls back to entry 0 and raises its count
    write_scan_length(0);
    send_beat(pncm_pkg::FUNC_LOAD, '0, '0);
    for (i = 0; i < FALLBACK_QUERIES; i++)
      send_beat(pncm_pkg::FUNC_QUERY, IN_INDEX_W'($urandom), rand_rgb());

    // heavily used entry: exact hit still qualifies, the far colour misses the limit
    write_scan_length(1);
    send_beat(pncm_pkg::FUNC_QUERY, IN_INDEX_W'($urandom), '0);
    send_beat(pncm_pkg::FUNC_QUERY, IN_INDEX_W'($urandom), '1);

    random_traffic(FILL_ENTRIES, 40);
    random_traffic(8, 60);

    wait_all_matched();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (board.mismatches == 0 && board.all_matched()) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
